/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* hw/rtl/ptek_pkg.sv */
// types, constants and helpers of the triangle element kernel
package ptek_pkg;

  localparam int DIFF_W = 33;
  localparam int DET_W  = 66;
  localparam int NUM_W  = 112;
  localparam int REM_W  = DET_W + 1;
  localparam int CNT_W  = 7;

  localparam int LOAD_SHIFT = 17;
  localparam int LOAD_STEPS = 6;
  localparam logic [17:0] DIV3_MUL = 18'd174763;
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;
  localparam int ENTRY_SHIFT = 15;

  localparam logic [2:0] JOB_LOAD = 3'd6;

  typedef struct packed {
    logic signed [DIFF_W-1:0] p0;
    logic signed [DIFF_W-1:0] p1;
    logic signed [DIFF_W-1:0] p2;
    logic signed [DIFF_W-1:0] q0;
    logic signed [DIFF_W-1:0] q1;
    logic signed [DIFF_W-1:0] q2;
    logic [DET_W-1:0]         detmag;
    logic                     degen;
    logic [31:0]              kmag;
    logic                     kneg;
    logic [31:0]              fmag;
    logic                     fneg;
    logic [2:0]               fix;
  } elem_t;

  // upper triangle order: 00 01 02 11 12 22
  function automatic logic [1:0] job_row(input logic [2:0] j);
    case (j)
      3'd0, 3'd1, 3'd2: job_row = 2'd0;
      3'd3, 3'd4:       job_row = 2'd1;
      default:          job_row = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] job_col(input logic [2:0] j);
    case (j)
      3'd0:       job_col = 2'd0;
      3'd1, 3'd3: job_col = 2'd1;
      default:    job_col = 2'd2;
    endcase
  endfunction

endpackage

/* hw/rtl/ptek_front.sv */
// front part: edge differences, magnitudes and determinant pipeline
module ptek_front import ptek_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by_coord,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] source_value,
  input  logic signed [31:0] conductivity,
  input  logic               fixed_a,
  input  logic               fixed_b,
  input  logic               fixed_c,
  output logic               push,
  output elem_t              push_data,
  output logic [1:0]         inflight
);

  logic v1, v2;
  logic signed [DIFF_W-1:0] dx1, dy2, dx2, dy1;
  elem_t s1, s2;
  logic signed [DET_W-1:0] pa, pb;
  logic signed [DET_W:0] det;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    dx1 <= {bx[31], bx} - {ax[31], ax};
    dy2 <= {cy[31], cy} - {ay[31], ay};
    dx2 <= {cx[31], cx} - {ax[31], ax};
    dy1 <= {by_coord[31], by_coord} - {ay[31], ay};
    s1.p0 <= {by_coord[31], by_coord} - {cy[31], cy};
    s1.p1 <= {cy[31], cy} - {ay[31], ay};
    s1.p2 <= {ay[31], ay} - {by_coord[31], by_coord};
    s1.q0 <= {cx[31], cx} - {bx[31], bx};
    s1.q1 <= {ax[31], ax} - {cx[31], cx};
    s1.q2 <= {bx[31], bx} - {ax[31], ax};
    s1.detmag <= '0;
    s1.degen <= 1'b0;
    s1.kneg <= conductivity[31];
    s1.kmag <= conductivity[31] ? (~conductivity + 32'd1) : conductivity;
    s1.fneg <= source_value[31];
    s1.fmag <= source_value[31] ? (~source_value + 32'd1) : source_value;
    s1.fix <= {fixed_c, fixed_b, fixed_a};
    pa <= dx1 * dy2;
    pb <= dx2 * dy1;
    s2 <= s1;
  end

  always_comb begin
    det = {pa[DET_W-1], pa} - {pb[DET_W-1], pb};
    push_data = s2;
    push_data.detmag = det[DET_W] ? DET_W'(-det) : det[DET_W-1:0];
    push_data.degen = (det == '0);
  end

  assign push = v2;
  assign inflight = {1'b0, v1} + {1'b0, v2};

endmodule

/* hw/rtl/ptek_queue.sv */
// short queue of classified elements between front and back
`include "assert_macros.svh"
module ptek_queue import ptek_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  elem_t                      din,
  input  logic                       pop,
  output elem_t                      dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  elem_t store [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (pop) rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      count <= count + CW'(push) - CW'(pop);
    end
    if (push) store[wptr] <= din;
  end

  assign dout = store[rptr];

  `ASSERT_NEVER(a_q_ovf, clk, rst, push && !pop && count == CW'(DEPTH), "queue overflow")
  `ASSERT_NEVER(a_q_udf, clk, rst, pop && count == '0, "queue underflow")
  `ASSERT_AT(a_q_hold, clk, rst, (!push && !pop) |=> $stable(count), "queue count moved")

endmodule

/* hw/rtl/ptek_back.sv */
// back part: entry and load sequencer with shared multiplier and divider
`include "assert_macros.svh"
module ptek_back import ptek_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        not_empty,
  input  elem_t       head,
  output logic        pop,
  output logic        done,
  output logic [1:0]  row_index,
  output logic [63:0] entry_zero,
  output logic [63:0] entry_one,
  output logic [63:0] entry_two,
  output logic [63:0] load_entry,
  output logic        degenerate,
  output logic        last_row
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SETUP = 4'd1;
  localparam logic [3:0] ST_PP    = 4'd2;
  localparam logic [3:0] ST_QQ    = 4'd3;
  localparam logic [3:0] ST_NSUM  = 4'd4;
  localparam logic [3:0] ST_ML    = 4'd5;
  localparam logic [3:0] ST_MH    = 4'd6;
  localparam logic [3:0] ST_MJOIN = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_STORE = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;
  localparam logic [3:0] ST_LDIV  = 4'd11;

  logic [3:0] st;
  logic [2:0] job;
  logic [1:0] erow;
  elem_t cur;
  logic signed [67:0] prod, tsum, nsum;
  logic [DET_W-1:0] nmag, den, src;
  logic nneg, sneg;
  logic [NUM_W-1:0] dvd, quo, full;
  logic [REM_W-1:0] rem, remsh;
  logic ge;
  logic [CNT_W-1:0] cnt;
  logic [63:0] ent [6];
  logic [63:0] lq, satv;
  logic [1:0] r, c;
  logic signed [DIFF_W-1:0] pr, pc, qr, qc;
  logic signed [33:0] ma, mb;
  logic [31:0] mag;
  logic is_load;
  logic [17:0] lv;
  logic [35:0] lprod;
  logic [15:0] lqd;
  logic [1:0] lrem;

  function automatic logic signed [DIFF_W-1:0] pick(input logic [1:0] i,
      input logic signed [DIFF_W-1:0] a0, input logic signed [DIFF_W-1:0] a1,
      input logic signed [DIFF_W-1:0] a2);
    case (i)
      2'd0:    pick = a0;
      2'd1:    pick = a1;
      default: pick = a2;
    endcase
  endfunction

  always_comb begin
    r = job_row(job);
    c = job_col(job);
    is_load = (job == JOB_LOAD);
    pr = pick(r, cur.p0, cur.p1, cur.p2);
    pc = pick(c, cur.p0, cur.p1, cur.p2);
    qr = pick(r, cur.q0, cur.q1, cur.q2);
    qc = pick(c, cur.q0, cur.q1, cur.q2);
    src = is_load ? cur.detmag : nmag;
    mag = is_load ? cur.fmag : cur.kmag;
    case (st)
      ST_PP: begin
        ma = {pr[DIFF_W-1], pr};
        mb = {pc[DIFF_W-1], pc};
      end
      ST_QQ: begin
        ma = {qr[DIFF_W-1], qr};
        mb = {qc[DIFF_W-1], qc};
      end
      ST_MH: begin
        ma = {1'b0, src[65:33]};
        mb = {2'b00, mag};
      end
      default: begin
        ma = {1'b0, src[32:0]};
        mb = {2'b00, mag};
      end
    endcase
    nsum = tsum + prod;
    full = NUM_W'({prod[64:0], 33'b0}) + NUM_W'(tsum[64:0]);
    remsh = {rem[REM_W-2:0], dvd[NUM_W-1]};
    ge = remsh >= {1'b0, den};
    // divide by three, 16 bits a step, by reciprocal multiplication
    lv = {rem[1:0], dvd[NUM_W-1 -: 16]};
    lprod = 36'(lv) * 36'(DIV3_MUL);
    lqd = lprod[34:19];
    lrem = 2'(lv - 18'(lqd) * 18'd3);
    if (sneg) satv = (|quo[NUM_W-1:63]) ? SAT_MIN : (~quo[63:0] + 64'd1);
    else satv = (|quo[NUM_W-1:63]) ? SAT_MAX : quo[63:0];
  end

  assign pop = (st == ST_IDLE) && not_empty;

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      st <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == ST_EMIT);
      case (st)
        ST_IDLE: begin
          if (not_empty) begin
            cur <= head;
            job <= '0;
            st <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (is_load) begin
            if (cur.degen) begin
              lq <= '0;
              erow <= '0;
              st <= ST_EMIT;
            end else begin
              st <= ST_ML;
            end
          end else if (cur.degen) begin
            ent[job] <= '0;
            job <= job + 3'd1;
          end else if (cur.fix[r] || cur.fix[c]) begin
            ent[job] <= (r == c) ? ONE_Q32 : '0;
            job <= job + 3'd1;
          end else begin
            st <= ST_PP;
          end
        end
        ST_PP: st <= ST_QQ;
        ST_QQ: begin
          tsum <= prod;
          st <= ST_NSUM;
        end
        ST_NSUM: begin
          nneg <= nsum[67];
          nmag <= nsum[67] ? DET_W'(-nsum) : nsum[DET_W-1:0];
          st <= ST_ML;
        end
        ST_ML: st <= ST_MH;
        ST_MH: begin
          tsum <= prod;
          st <= ST_MJOIN;
        end
        ST_MJOIN: begin
          dvd <= is_load ? {1'b0, full[NUM_W-1:LOAD_SHIFT], 16'b0} : (full << ENTRY_SHIFT);
          den <= cur.detmag;
          sneg <= is_load ? cur.fneg : (nneg ^ cur.kneg);
          rem <= '0;
          quo <= '0;
          cnt <= '0;
          st <= is_load ? ST_LDIV : ST_DIV;
        end
        ST_DIV: begin
          rem <= ge ? (remsh - {1'b0, den}) : remsh;
          quo <= {quo[NUM_W-2:0], ge};
          dvd <= dvd << 1;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NUM_W - 1)) st <= ST_STORE;
        end
        ST_LDIV: begin
          rem <= REM_W'(lrem);
          quo <= {quo[NUM_W-17:0], lqd};
          dvd <= dvd << 16;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(LOAD_STEPS - 1)) st <= ST_STORE;
        end
        ST_STORE: begin
          if (is_load) begin
            lq <= satv;
            erow <= '0;
            st <= ST_EMIT;
          end else begin
            ent[job] <= satv;
            job <= job + 3'd1;
            st <= ST_SETUP;
          end
        end
        ST_EMIT: begin
          erow <= erow + 2'd1;
          if (erow == 2'd2) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
    if (st == ST_EMIT) begin
      row_index <= erow;
      degenerate <= cur.degen;
      last_row <= (erow == 2'd2);
      load_entry <= cur.fix[erow] ? '0 : lq;
      case (erow)
        2'd0: begin
          entry_zero <= ent[0];
          entry_one <= ent[1];
          entry_two <= ent[2];
        end
        2'd1: begin
          entry_zero <= ent[1];
          entry_one <= ent[3];
          entry_two <= ent[4];
        end
        default: begin
          entry_zero <= ent[2];
          entry_one <= ent[4];
          entry_two <= ent[5];
        end
      endcase
    end
  end

  `ASSERT_AT(a_emit_done, clk, rst, (st == ST_EMIT) |=> done, "row not strobed")
  `ASSERT_AT(a_pop_setup, clk, rst, pop |=> (st == ST_SETUP && job == 3'd0), "bad start")
  `ASSERT_AT(a_div_run, clk, rst, (st == ST_DIV && cnt != CNT_W'(NUM_W - 1)) |=> st == ST_DIV,
             "divider cut short")

endmodule

/* hw/rtl/poisson_triangle_element_kernel.sv */
// top level of the linear triangle element stiffness and load kernel
//
//   channel   handshake            payload
//   element   start / busy         ax ay bx by_coord cx cy source_value conductivity fixed_*
//   row       done (one cycle)     row_index entry_* load_entry degenerate last_row
//
// in the back part an element runs six matrix entries, each through one shared radix-2
// divider running 112 steps, then a load whose divide by three runs in six 16-bit steps,
// then three rows of output; picking up the element from the queue takes its own state
// fixed or degenerate entries skip multiply and divide, as does a degenerate element's load
// the front pipeline and the queue together buffer up to QUEUE_DEPTH elements
// rst is synchronous and clears the sequencer state, valid bits and queue pointers; rows cannot be held off
module poisson_triangle_element_kernel import ptek_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by_coord,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] source_value,
  input  logic signed [31:0] conductivity,
  input  logic               fixed_a,
  input  logic               fixed_b,
  input  logic               fixed_c,
  output logic               done,
  output logic [1:0]         row_index,
  output logic signed [63:0] entry_zero,
  output logic signed [63:0] entry_one,
  output logic signed [63:0] entry_two,
  output logic signed [63:0] load_entry,
  output logic               degenerate,
  output logic               last_row
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic push, pop;
  elem_t push_data, head;
  logic [1:0] inflight;
  logic [CW-1:0] count;
  logic [CW+1:0] used;

  assign used = (CW + 2)'(count) + (CW + 2)'(inflight);
  assign busy = used >= (CW + 2)'(QUEUE_DEPTH);

  ptek_front u_front (
    .clk, .rst,
    .in_valid(start && !busy),
    .ax, .ay, .bx, .by_coord, .cx, .cy, .source_value, .conductivity,
    .fixed_a, .fixed_b, .fixed_c,
    .push, .push_data, .inflight
  );

  ptek_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .din(push_data), .pop, .dout(head), .count
  );

  ptek_back u_back (
    .clk, .rst,
    .not_empty(count != '0),
    .head, .pop, .done, .row_index,
    .entry_zero, .entry_one, .entry_two, .load_entry,
    .degenerate, .last_row
  );

endmodule

/* tb/poisson_triangle_element_kernel_tb.sv */
// self-checking testbench of the triangle element stiffness and load kernel
module poisson_triangle_element_kernel_tb;
  import ptek_pkg::*;

  typedef struct {
    logic [1:0]  row;
    logic [63:0] e0;
    logic [63:0] e1;
    logic [63:0] e2;
    logic [63:0] ld;
    logic        degen;
    logic        last;
  } row_t;

  localparam int LIMIT = 2000000;
  localparam logic signed [159:0] BIG_POS = 160'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [159:0] BIG_NEG = -BIG_POS - 160'sd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] ax = '0, ay = '0, bx = '0, by_coord = '0, cx = '0, cy = '0;
  logic signed [31:0] source_value = '0, conductivity = '0;
  logic fixed_a = 1'b0, fixed_b = 1'b0, fixed_c = 1'b0;
  logic done;
  logic [1:0] row_index;
  logic signed [63:0] entry_zero, entry_one, entry_two, load_entry;
  logic degenerate, last_row;

  row_t expected_rows[$];
  int errors = 0;
  int cycles = 0;
  int elements = 0;
  int rows_seen = 0;
  int degen_count = 0;

  poisson_triangle_element_kernel dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord), .cx(cx), .cy(cy),
    .source_value(source_value), .conductivity(conductivity),
    .fixed_a(fixed_a), .fixed_b(fixed_b), .fixed_c(fixed_c),
    .done(done), .row_index(row_index), .entry_zero(entry_zero),
    .entry_one(entry_one), .entry_two(entry_two), .load_entry(load_entry),
    .degenerate(degenerate), .last_row(last_row)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [63:0] clamp64(input logic signed [159:0] v);
    if (v > BIG_POS) return BIG_POS[63:0];
    if (v < BIG_NEG) return BIG_NEG[63:0];
    return v[63:0];
  endfunction

  // exact element stiffness and load, three rows per element
  task automatic predict_element(
    input logic signed [31:0] x0, y0, x1, y1, x2, y2, f, k,
    input logic [2:0] fix
  );
    logic signed [159:0] p[3], q[3], det, dm, nn, lq;
    logic [63:0] m[3][3];
    logic [63:0] ld[3];
    logic degen;
    row_t r;
    p[0] = 160'(y1) - 160'(y2); p[1] = 160'(y2) - 160'(y0); p[2] = 160'(y0) - 160'(y1);
    q[0] = 160'(x2) - 160'(x1); q[1] = 160'(x0) - 160'(x2); q[2] = 160'(x1) - 160'(x0);
    det = q[2] * (160'(y2) - 160'(y0)) - (160'(x2) - 160'(x0)) * (160'(y1) - 160'(y0));
    dm = det < 0 ? -det : det;
    degen = det == 0;
    for (int i = 0; i < 3; i++) begin
      ld[i] = '0;
      for (int j = 0; j < 3; j++) m[i][j] = '0;
    end
    if (!degen) begin
      lq = (160'(f) * dm) / 160'sd393216;
      for (int i = 0; i < 3; i++) begin
        ld[i] = fix[i] ? 64'd0 : clamp64(lq);
        for (int j = 0; j < 3; j++) begin
          if (fix[i] || fix[j]) m[i][j] = (i == j) ? ONE_Q32 : 64'd0;
          else begin
            nn = p[i] * p[j] + q[i] * q[j];
            m[i][j] = clamp64((160'(k) * nn * 160'sd32768) / dm);
          end
        end
      end
    end else degen_count++;
    for (int i = 0; i < 3; i++) begin
      r.row = 2'(i); r.e0 = m[i][0]; r.e1 = m[i][1]; r.e2 = m[i][2];
      r.ld = ld[i]; r.degen = degen; r.last = (i == 2);
      expected_rows.push_back(r);
    end
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if (n > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_element(
    input logic signed [31:0] x0, y0, x1, y1, x2, y2, f, k,
    input logic [2:0] fix, input bit gaps
  );
    @(negedge clk);
    ax <= x0; ay <= y0; bx <= x1; by_coord <= y1; cx <= x2; cy <= y2;
    source_value <= f; conductivity <= k;
    fixed_a <= fix[0]; fixed_b <= fix[1]; fixed_c <= fix[2];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_element(x0, y0, x1, y1, x2, y2, f, k, fix);
    elements++;
    if (gaps) idle_gap();
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (900) @(negedge clk);
  endtask

  always @(posedge clk) begin
    row_t e;
    if (!rst && done) begin
      rows_seen++;
      if (expected_rows.size() == 0) begin
        $error("row transaction with nothing expected");
        errors++;
      end else begin
        e = expected_rows.pop_front();
        if (row_index !== e.row) begin
          $error("row_index exp %0d got %0d", e.row, row_index); errors++;
        end
        if (entry_zero !== e.e0) begin
          $error("entry_zero exp %h got %h", e.e0, entry_zero); errors++;
        end
        if (entry_one !== e.e1) begin
          $error("entry_one exp %h got %h", e.e1, entry_one); errors++;
        end
        if (entry_two !== e.e2) begin
          $error("entry_two exp %h got %h", e.e2, entry_two); errors++;
        end
        if (load_entry !== e.ld) begin
          $error("load_entry exp %h got %h", e.ld, load_entry); errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, degenerate); errors++;
        end
        if (last_row !== e.last) begin
          $error("last_row exp %0d got %0d", e.last, last_row); errors++;
        end
      end
    end
  end

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  task automatic test_flags();
    for (int i = 0; i < 8; i++)
      send_element(0, 0, ONE, 0, 0, ONE, 3 * ONE, ONE, 3'(i), 1'b1);
  endtask

  task automatic test_degenerate();
    send_element(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, ONE, ONE, 3'b000, 1'b0);
    send_element(5, 5, 5, 5, 5, 5, MAXV, MINV, 3'b101, 1'b0);
    send_element(MINV, MINV, MINV, MINV, MAXV, MAXV, ONE, ONE, 3'b111, 1'b1);
  endtask

  task automatic test_extremes();
    send_element(MINV, MINV, MAXV, MINV, MINV, MAXV, MAXV, MAXV, 3'b000, 1'b0);
    send_element(MAXV, MAXV, MINV, MAXV, MAXV, MINV, MINV, MINV, 3'b000, 1'b1);
    send_element(0, 0, 1, 0, 0, 1, MAXV, MAXV, 3'b000, 1'b0);
    send_element(0, 0, MAXV, 1, 1, MAXV, MINV, MINV, 3'b000, 1'b0);
    send_element(0, 0, ONE, 0, 0, ONE, -ONE, -2 * ONE, 3'b000, 1'b0);
    send_element(0, 0, 2 * ONE, 0, 0, 2 * ONE, 0, 0, 3'b010, 1'b1);
    send_element(-1, -1, ONE, -ONE, ONE, ONE, MAXV, -1, 3'b100, 1'b1);
  endtask

  function automatic logic signed [31:0] rand_coord(input bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(0, 2 * 64 * 65536)) - 64 * 65536;
  endfunction

  task automatic test_random(input int n);
    logic signed [31:0] c[6];
    logic signed [31:0] f, k;
    bit wide;
    for (int i = 0; i < n; i++) begin
      wide = $urandom_range(0, 3) == 0;
      foreach (c[j]) c[j] = rand_coord(wide);
      if ($urandom_range(0, 9) == 0) begin
        c[4] = c[0] + 2 * (c[2] - c[0]);
        c[5] = c[1] + 2 * (c[3] - c[1]);
      end
      f = $urandom_range(0, 3) == 0 ? $urandom : rand_coord(1'b0);
      k = $urandom_range(0, 3) == 0 ? $urandom : rand_coord(1'b0);
      send_element(c[0], c[1], c[2], c[3], c[4], c[5], f, k,
                   $urandom_range(0, 1) ? 3'b000 : 3'($urandom), $urandom_range(0, 2) != 0);
      if (i == n / 2) begin
        @(negedge clk) start <= 1'b0;
        while (expected_rows.size() != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_flags();
    test_degenerate();
    test_extremes();
    test_random(292);
    drain();
    $display("ran %0d elements (%0d degenerate), checked %0d rows", elements,
             degen_count, rows_seen);
    $display("covered all boundary flag sets, extreme fields and random triangles");
    if (errors == 0 && expected_rows.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
